// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SVA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/sva_pkg.sv
// Types and constants of the voice allocator.
package sva_pkg;

  localparam int CMD_W      = 2;
  localparam int ENT_W      = 10;
  localparam int SUB_W      = 3;
  localparam int TIME_W     = 31;
  localparam int SLOT_W     = 5;
  localparam int ACT_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cmd_t CMD_ALLOC    = 2'd0;
  localparam cmd_t CMD_STOP     = 2'd1;
  localparam cmd_t CMD_STOP_RAW = 2'd2;

  localparam cfg_idx_t CFG_ACTIVE_SLOTS  = 2'd0;
  localparam cfg_idx_t CFG_PLAYER_ENTITY = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0] active_slots;
    logic [ENT_W-1:0] player_entity;
  } cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ENT_W-1:0]  entity;
    logic [SUB_W-1:0]  sub_channel;
    logic [TIME_W-1:0] now_time;
    logic              as_stream;
    logic [SLOT_W-1:0] target_slot;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot;
  } res_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [ENT_W-1:0]  entity;
    logic [SUB_W-1:0]  sub_channel;
    logic [TIME_W-1:0] start;
  } slot_rec_t;

endpackage

// File: hdl/sva_ifs.sv
// Handshake interfaces of the request, result and configuration channels.
interface sva_in_if;
  logic                          valid;
  logic                          ready;
  logic [sva_pkg::CMD_W-1:0]     cmd;
  logic [sva_pkg::ENT_W-1:0]     entity;
  logic [sva_pkg::SUB_W-1:0]     sub_channel;
  logic [sva_pkg::TIME_W-1:0]    now_time;
  logic                          as_stream;
  logic [sva_pkg::SLOT_W-1:0]    target_slot;

  modport source (output valid, cmd, entity, sub_channel, now_time, as_stream, target_slot,
                  input ready);
  modport sink (input valid, cmd, entity, sub_channel, now_time, as_stream, target_slot,
                output ready);
endinterface

interface sva_out_if;
  logic                       valid;
  logic                       ready;
  logic                       granted;
  logic [sva_pkg::SLOT_W-1:0] slot;

  modport source (output valid, granted, slot, input ready);
  modport sink (input valid, granted, slot, output ready);
endinterface

interface sva_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sva_pkg::CFG_IDX_W-1:0]  index;
  logic [sva_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/sva_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sva_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sva_ctrl.sv
// Sequencer of the allocator: slot scan over the memory, flags and write-back.
module sva_ctrl #(
  parameter int NUM_SLOTS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sva_pkg::cfg_t           cfg,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  sva_pkg::req_t           req,
  output logic                    res_valid,
  output sva_pkg::res_t           res,
  input  logic                    res_take,
  output logic                    ram_we,
  output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] ram_waddr,
  output sva_pkg::slot_rec_t      ram_wdata,
  output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] ram_raddr,
  input  sva_pkg::slot_rec_t      ram_rdata
);
  import sva_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  state_t                state_r, state_nxt;
  req_t                  req_r, req_nxt;
  logic [CW-1:0]         lim_r, lim_nxt;
  logic [CW-1:0]         iss_r, iss_nxt;
  logic                  ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]         ev_idx_r, ev_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         choice_r, choice_nxt;
  logic [TIME_W-1:0]     oldest_r, oldest_nxt;
  logic [NUM_SLOTS-1:0]  busy_r, busy_nxt;
  logic [NUM_SLOTS-1:0]  stream_r, stream_nxt;

  logic                  e_stream, e_busy, e_hit, e_prot, e_old;
  logic [CW-1:0]         lim_req;
  logic [IW-1:0]         tgt_idx;
  logic                  tgt_ok;

  // Evaluation of the slot whose memory entry has just come back.
  always_comb begin
    e_stream = stream_r[ev_idx_r];
    e_busy   = busy_r[ev_idx_r];
    e_hit    = !e_stream &&
               (!e_busy || (req_r.sub_channel != '0 &&
                            ram_rdata.entity == req_r.entity &&
                            ram_rdata.sub_channel == req_r.sub_channel));
    e_prot   = (ram_rdata.entity == cfg.player_entity) &&
               (req_r.entity != cfg.player_entity);
    e_old    = !e_stream && e_busy && !e_prot && (ram_rdata.start < oldest_r);
  end

  always_comb begin
    if (32'(cfg.active_slots) > NUM_SLOTS) begin
      lim_req = CW'(NUM_SLOTS);
    end else begin
      lim_req = CW'(cfg.active_slots);
    end
    tgt_idx = IW'(req_r.target_slot);
    tgt_ok  = 32'(req_r.target_slot) < NUM_SLOTS;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    lim_nxt    = lim_r;
    iss_nxt    = iss_r;
    ev_vld_nxt = ev_vld_r;
    ev_idx_nxt = ev_idx_r;
    found_nxt  = found_r;
    choice_nxt = choice_r;
    oldest_nxt = oldest_r;
    busy_nxt   = busy_r;
    stream_nxt = stream_r;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    ram_we     = 1'b0;
    ram_waddr  = choice_r;
    ram_wdata  = '{entity: req_r.entity, sub_channel: req_r.sub_channel,
                   start: req_r.now_time};
    ram_raddr  = iss_r[IW-1:0];

    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt    = req;
          lim_nxt    = lim_req;
          iss_nxt    = '0;
          ev_vld_nxt = 1'b0;
          found_nxt  = 1'b0;
          choice_nxt = '0;
          oldest_nxt = req.now_time;
          state_nxt  = (req.cmd == CMD_ALLOC) ? ST_SCAN : ST_FINISH;
        end
      end

      ST_SCAN: begin
        if (ev_vld_r && e_hit) begin
          found_nxt  = 1'b1;
          choice_nxt = ev_idx_r;
          ev_vld_nxt = 1'b0;
          state_nxt  = ST_FINISH;
        end else begin
          if (ev_vld_r && e_old) begin
            oldest_nxt = ram_rdata.start;
            choice_nxt = ev_idx_r;
            found_nxt  = 1'b1;
          end
          if (iss_r != lim_r) begin
            ev_vld_nxt = 1'b1;
            ev_idx_nxt = iss_r[IW-1:0];
            iss_nxt    = iss_r + CW'(1);
          end else begin
            ev_vld_nxt = 1'b0;
            if (!ev_vld_r) begin
              state_nxt = ST_FINISH;
            end
          end
        end
      end

      ST_FINISH: begin
        res_valid = 1'b1;
        case (req_r.cmd)
          CMD_ALLOC: begin
            res.granted = found_r;
            res.slot    = found_r ? SLOT_W'(choice_r) : '0;
          end
          CMD_STOP, CMD_STOP_RAW: begin
            res.slot = req_r.target_slot;
          end
          default: begin
            res = '0;
          end
        endcase
        if (res_take) begin
          state_nxt = ST_IDLE;
          case (req_r.cmd)
            CMD_ALLOC: begin
              if (found_r) begin
                ram_we               = 1'b1;
                busy_nxt[choice_r]   = !req_r.as_stream;
                stream_nxt[choice_r] = req_r.as_stream;
              end
            end
            CMD_STOP: begin
              if (tgt_ok) begin
                busy_nxt[tgt_idx] = 1'b0;
              end
            end
            CMD_STOP_RAW: begin
              if (tgt_ok) begin
                stream_nxt[tgt_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ev_vld_r <= 1'b0;
      busy_r   <= '0;
      stream_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ev_vld_r <= ev_vld_nxt;
      busy_r   <= busy_nxt;
      stream_r <= stream_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    lim_r    <= lim_nxt;
    iss_r    <= iss_nxt;
    ev_idx_r <= ev_idx_nxt;
    found_r  <= found_nxt;
    choice_r <= choice_nxt;
    oldest_r <= oldest_nxt;
  end

endmodule

// File: hdl/sound_voice_allocator_top.sv
// Top level of the voice allocator: configuration registers, slot memory and result register.
//
//   channel   direction  handshake       contents
//   in_ch     in         valid / ready   cmd, entity, sub_channel, now_time, as_stream,
//                                        target_slot
//   out_ch    out        valid / ready   granted, slot
//   cfg_ch    in         valid / ready   index (0 active_slots, 1 player_entity), data
//
// One item is in work at a time. An allocate scans up to min(active_slots, NUM_SLOTS) slots,
// fewer when a free or matching slot ends the scan early; a stop needs no scan. The slot
// memory is read one slot per cycle during the scan.
// Reset is synchronous and active low; it clears the busy and stream flags at once, while
// the entity, sub-channel and start-time memory is left as is and needs no clearing pass.
// A finished result waits in the output register; the next item is taken meanwhile and
// only stalls in its finish state if the previous result has still not been taken.
module sound_voice_allocator_top #(
  parameter int NUM_SLOTS = 32
) (
  input logic      clk,
  input logic      rst_n,
  sva_in_if.sink   in_ch,
  sva_out_if.source out_ch,
  sva_cfg_if.sink  cfg_ch
);
  import sva_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  cfg_t       cfg_r, cfg_nxt;
  res_t       out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;

  req_t       req;
  res_t       res;
  logic       res_valid;
  logic       res_take;

  logic       ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  slot_rec_t  ram_wdata;
  slot_rec_t  ram_rdata;
  logic [$bits(slot_rec_t)-1:0] ram_rdata_raw;

  // Configuration writes are always taken; indexes past the list are ignored.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ACTIVE_SLOTS:  cfg_nxt.active_slots  = cfg_ch.data[ACT_W-1:0];
        CFG_PLAYER_ENTITY: cfg_nxt.player_entity = cfg_ch.data[ENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    req.cmd         = in_ch.cmd;
    req.entity      = in_ch.entity;
    req.sub_channel = in_ch.sub_channel;
    req.now_time    = in_ch.now_time;
    req.as_stream   = in_ch.as_stream;
    req.target_slot = in_ch.target_slot;
  end

  // The result register loads when it is empty or being emptied in the same cycle.
  assign res_take = !out_valid_r || out_ch.ready;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_slots  <= ACT_W'(32);
      cfg_r.player_entity <= ENT_W'(1);
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.granted = out_r.granted;
  assign out_ch.slot    = out_r.slot;

  sva_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Entity, sub-channel and start time of every slot, one entry per slot.
  sva_ram #(
    .WIDTH($bits(slot_rec_t)),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = slot_rec_t'(ram_rdata_raw);

endmodule

// File: hdl/sva_checker.sv
// Port-level checker of the voice allocator and its bind to the top level.
`include "assert_macros.svh"

module sva_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_granted,
  input logic [sva_pkg::SLOT_W-1:0] out_slot
);

  // A result that is not taken stays offered with the same contents.
  `SVA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_granted) && $stable(out_slot))

  // Only one item is in work: the request side closes right after an item is taken.
  `SVA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // A fresh result is presented exactly when the block has gone back to accepting items.
  `SVA_ASSERT_SAME(a_result_frees_input, clk, rst_n, $rose(out_valid), in_ready)

endmodule

bind sound_voice_allocator_top sva_checker u_sva_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_granted (out_ch.granted),
  .out_slot    (out_ch.slot)
);

// File: tb/tb.sv
// Self-checking testbench of the voice allocator: stimulus, slot-table prediction and result check.
`timescale 1ns / 100ps

module tb;
  import sva_pkg::*;

  localparam int NUM_SLOTS   = 32;
  // Cycles in which no item, result or register write moves before the run is declared hung.
  // The slowest item is a full scan plus the longest sender gap and receiver stall.
  localparam int STALL_LIMIT = 3000;

  // Codes that the package leaves unnamed: the spare command and a spare register index.
  localparam cmd_t     CMD_UNUSED = 2'd3;
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  sva_in_if  in_bus();
  sva_out_if out_bus();
  sva_cfg_if cfg_bus();

  sound_voice_allocator_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  // Local copies of everything the testbench drives. Their initial values make every input
  // of the block known from time zero; the interfaces simply follow them.
  logic             req_valid = 1'b0;
  req_t             req_cur   = '0;
  logic             out_rdy   = 1'b1;
  logic             cfg_valid = 1'b0;
  cfg_idx_t         cfg_idx   = '0;
  logic [ENT_W-1:0] cfg_data  = '0;

  assign in_bus.valid       = req_valid;
  assign in_bus.cmd         = req_cur.cmd;
  assign in_bus.entity      = req_cur.entity;
  assign in_bus.sub_channel = req_cur.sub_channel;
  assign in_bus.now_time    = req_cur.now_time;
  assign in_bus.as_stream   = req_cur.as_stream;
  assign in_bus.target_slot = req_cur.target_slot;
  assign out_bus.ready      = out_rdy;
  assign cfg_bus.valid      = cfg_valid;
  assign cfg_bus.index      = cfg_idx;
  assign cfg_bus.data       = cfg_data;

  // Items waiting to be sent, and the grants predicted for items already accepted.
  req_t pending_reqs[$];
  res_t expected_grants[$];

  int   fail_cnt   = 0;
  int   idle_count = 0;
  int   send_gap   = 0;
  int   stall_left = 0;
  logic in_taken   = 1'b0;
  // When set, neither side idles, so items go back to back against a ready receiver.
  bit   calm       = 1'b0;

  // Predicted slot table and register copies, updated in the order the block accepts items.
  bit               busy_tbl   [NUM_SLOTS];
  bit               stream_tbl [NUM_SLOTS];
  bit [ENT_W-1:0]   ent_tbl    [NUM_SLOTS];
  bit [SUB_W-1:0]   sub_tbl    [NUM_SLOTS];
  bit [TIME_W-1:0]  start_tbl  [NUM_SLOTS];
  logic [ACT_W-1:0] act_cfg    = 6'd32;
  logic [ENT_W-1:0] player_cfg = 10'd1;

  // The stimulus side keeps its own view of the registers and of the time of day.
  int                gen_act    = 32;
  logic [ENT_W-1:0]  gen_player = 10'd1;
  logic [TIME_W-1:0] gen_ms     = '0;

  // Gap and stall lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Scans the active slots the way the allocator does. A free slot or a busy slot of the same
  // entity and same nonzero sub-channel ends the scan at once; otherwise the oldest stealable
  // slot that started strictly before now wins, the lowest index on a tie. Stream slots are never
  // taken, and the player's slots are off limits to every other entity.
  function automatic int find_voice(logic [ENT_W-1:0] ent, logic [SUB_W-1:0] sub,
                                    logic [TIME_W-1:0] now);
    int                lim;
    int                choice;
    logic [TIME_W-1:0] oldest;
    lim    = (act_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(act_cfg);
    oldest = now;
    choice = -1;
    for (int i = 0; i < lim; i++) begin
      if (!stream_tbl[i]) begin
        if (!busy_tbl[i]) return i;
        if (sub != 0 && ent_tbl[i] == ent && sub_tbl[i] == sub) return i;
        if (!(ent_tbl[i] == player_cfg && ent != player_cfg) && start_tbl[i] < oldest) begin
          oldest = start_tbl[i];
          choice = i;
        end
      end
    end
    return choice;
  endfunction

  // Applies one accepted item to the predicted table and returns the grant it should produce.
  function automatic res_t apply_request(req_t r);
    res_t res;
    int   pick;
    res = '0;
    case (r.cmd)
      CMD_ALLOC: begin
        pick = find_voice(r.entity, r.sub_channel, r.now_time);
        if (pick >= 0) begin
          ent_tbl[pick]    = r.entity;
          sub_tbl[pick]    = r.sub_channel;
          start_tbl[pick]  = r.now_time;
          busy_tbl[pick]   = !r.as_stream;
          stream_tbl[pick] = r.as_stream;
          res.granted      = 1'b1;
          res.slot         = pick[SLOT_W-1:0];
        end
      end
      CMD_STOP: begin
        busy_tbl[r.target_slot] = 1'b0;
        res.slot = r.target_slot;
      end
      CMD_STOP_RAW: begin
        stream_tbl[r.target_slot] = 1'b0;
        res.slot = r.target_slot;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Item driver: new values go out at the falling edge, once the previous item was taken.
  always @(negedge clk) begin
    if (rst_n && (!req_valid || in_taken)) begin
      if (send_gap > 0) begin
        req_valid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        req_cur   <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        send_gap  <= pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result receiver: ready drops for random stretches, independent of what the block does.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_rdy    <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_rdy <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Monitor: at each rising edge it records register writes, predicts the grant of every
  // accepted item, checks every accepted result against the oldest prediction, and watches
  // for a hang.
  always @(posedge clk) begin : monitor
    res_t want;
    bit   moved;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      moved    = 1'b0;
      in_taken <= req_valid && in_bus.ready;

      if (cfg_valid && cfg_bus.ready) begin
        moved = 1'b1;
        case (cfg_idx)
          CFG_ACTIVE_SLOTS:  act_cfg = cfg_data[ACT_W-1:0];
          CFG_PLAYER_ENTITY: player_cfg = cfg_data;
          default: ;
        endcase
      end

      if (out_bus.valid && out_rdy) begin
        moved = 1'b1;
        if (expected_grants.size() == 0) begin
          $display("%0t: result with nothing expected, actual granted=%0b slot=%0d",
                   $time, out_bus.granted, out_bus.slot);
          fail_cnt++;
        end else begin
          want = expected_grants.pop_front();
          if (out_bus.granted !== want.granted) begin
            $display("%0t: granted mismatch, expected %0b, actual %0b",
                     $time, want.granted, out_bus.granted);
            fail_cnt++;
          end
          if (out_bus.slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, actual %0d",
                     $time, want.slot, out_bus.slot);
            fail_cnt++;
          end
        end
      end

      if (req_valid && in_bus.ready) begin
        moved = 1'b1;
        expected_grants.push_back(apply_request(req_cur));
      end

      if (moved) begin
        idle_count = 0;
      end else begin
        idle_count++;
        if (idle_count >= STALL_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
          $display("[sound_voice_allocator_top] ERROR");
          $finish;
        end
      end
    end
  end

  task automatic push_req(cmd_t cmd, logic [ENT_W-1:0] ent, logic [SUB_W-1:0] sub,
                          logic [TIME_W-1:0] now, logic strm, logic [SLOT_W-1:0] tgt);
    req_t r;
    r.cmd         = cmd;
    r.entity      = ent;
    r.sub_channel = sub;
    r.now_time    = now;
    r.as_stream   = strm;
    r.target_slot = tgt;
    pending_reqs.push_back(r);
  endtask

  // Waits until every queued item went out and every predicted grant came back.
  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [ENT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Entities are drawn from a small pool so that same-entity overrides and the player's
  // protection come up often.
  function automatic logic [ENT_W-1:0] pick_entity();
    case ($urandom_range(0, 6))
      0:       return gen_player;
      1:       return '0;
      2, 3:    return ENT_W'($urandom_range(2, 5));
      4:       return 10'h3FF;
      default: return ENT_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Random items over the current settings. The clock mostly creeps forward, sometimes
  // stands still so that equal start times block stealing, and now and then jumps anywhere
  // or slips back.
  task automatic add_random(int count, int alloc_pct);
    int               r;
    int               rest;
    int               lim;
    cmd_t             cmd;
    logic [SUB_W-1:0] sub;
    logic [SLOT_W-1:0] tgt;
    rest = 100 - alloc_pct;
    lim  = (gen_act > NUM_SLOTS) ? NUM_SLOTS : gen_act;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 3) gen_ms = TIME_W'($urandom);
      else if (r < 5) gen_ms = TIME_W'(gen_ms - $urandom_range(1, 20));
      else if (r >= 15) gen_ms = TIME_W'(gen_ms + $urandom_range(1, 4));

      r = $urandom_range(0, 99);
      if (r < alloc_pct) cmd = CMD_ALLOC;
      else if (r < alloc_pct + rest * 5 / 10) cmd = CMD_STOP;
      else if (r < alloc_pct + rest * 9 / 10) cmd = CMD_STOP_RAW;
      else cmd = CMD_UNUSED;

      r = $urandom_range(0, 9);
      if (r < 3) sub = '0;
      else if (r < 8) sub = SUB_W'($urandom_range(1, 3));
      else sub = SUB_W'($urandom_range(1, 7));

      if (lim > 0 && $urandom_range(0, 9) < 7) tgt = SLOT_W'($urandom_range(0, lim - 1));
      else tgt = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));

      push_req(cmd, pick_entity(), sub, gen_ms, $urandom_range(0, 99) < 12, tgt);
    end
  endtask

  // Settings of the random phases; a player entity of -1 means a random one.
  int phase_act    [10] = '{4, 1, 32, 3, 0, 2, 40, 8, 63, 6};
  int phase_player [10] = '{-1, 1, 1023, 0, -1, -1, 5, -1, 2, 3};

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on two slots, with entity 7 as the player.
    write_reg(CFG_ACTIVE_SLOTS, 10'd2);
    write_reg(CFG_PLAYER_ENTITY, 10'd7);
    gen_act    = 2;
    gen_player = 10'd7;
    push_req(CMD_ALLOC, 10'd7, 3'd1, 31'd10, 1'b0, 5'd0);   // free slot 0
    push_req(CMD_ALLOC, 10'd3, 3'd2, 31'd20, 1'b0, 5'd0);   // free slot 1
    push_req(CMD_ALLOC, 10'd3, 3'd2, 31'd30, 1'b0, 5'd0);   // same entity and sub-channel
    push_req(CMD_ALLOC, 10'd5, 3'd0, 31'd40, 1'b0, 5'd0);   // player protected, steal slot 1
    push_req(CMD_ALLOC, 10'd5, 3'd0, 31'd40, 1'b0, 5'd0);   // start not before now: refused
    push_req(CMD_ALLOC, 10'd7, 3'd0, 31'd50, 1'b0, 5'd0);   // player steals its own oldest
    push_req(CMD_STOP, 10'd0, 3'd0, 31'd0, 1'b0, 5'd0);
    push_req(CMD_ALLOC, 10'd0, 3'd0, 31'd0, 1'b1, 5'd0);    // becomes a stream slot
    push_req(CMD_ALLOC, 10'd2, 3'd3, 31'd60, 1'b0, 5'd0);   // stream slot skipped
    push_req(CMD_STOP_RAW, 10'd0, 3'd0, 31'd0, 1'b0, 5'd0);
    push_req(CMD_STOP_RAW, 10'd0, 3'd0, 31'd0, 1'b0, 5'd1); // not a stream slot
    push_req(CMD_UNUSED, 10'h3FF, 3'd7, 31'h7FFF_FFFF, 1'b1, 5'd31);
    push_req(CMD_ALLOC, 10'h3FF, 3'd7, 31'h7FFF_FFFF, 1'b0, 5'd31);
    push_req(CMD_STOP, 10'h3FF, 3'd7, 31'h7FFF_FFFF, 1'b1, 5'd31);
    push_req(CMD_ALLOC, 10'h3FF, 3'd7, 31'h7FFF_FFFF, 1'b0, 5'd0);
    push_req(CMD_ALLOC, 10'h3FF, 3'd7, 31'd0, 1'b1, 5'd0);  // override turns it into a stream
    drain();

    // No active slots: every allocate is refused.
    write_reg(CFG_ACTIVE_SLOTS, 10'd0);
    gen_act = 0;
    push_req(CMD_ALLOC, 10'd4, 3'd1, 31'd100, 1'b0, 5'd0);
    push_req(CMD_STOP, 10'd4, 3'd1, 31'd100, 1'b0, 5'd5);
    drain();

    // Upper data bits of the slot count are dropped; the spare register index does nothing.
    write_reg(CFG_ACTIVE_SLOTS, 10'h3E0);
    write_reg(CFG_PLAYER_ENTITY, 10'd0);
    write_reg(CFG_UNUSED, 10'h3FF);
    gen_act    = 32;
    gen_player = 10'd0;
    push_req(CMD_ALLOC, 10'd0, 3'd0, 31'd200, 1'b0, 5'd0);
    push_req(CMD_ALLOC, 10'h3FF, 3'd4, 31'd201, 1'b0, 5'd0);
    drain();

    // Random phases, each with its own settings; two of them run without any idling.
    for (int p = 0; p < 10; p++) begin
      gen_act    = phase_act[p];
      gen_player = (phase_player[p] < 0) ? 10'($urandom_range(0, 1023)) : 10'(phase_player[p]);
      write_reg(CFG_ACTIVE_SLOTS, 10'(gen_act));
      write_reg(CFG_PLAYER_ENTITY, gen_player);
      calm = (p == 2 || p == 7);
      if (p == 9) gen_ms = 31'h7FFF_FF00;
      add_random(120, (gen_act >= NUM_SLOTS) ? 80 : 55);
      drain();
    end

    calm = 1'b0;
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && expected_grants.size() == 0) begin
      $display("[sound_voice_allocator_top] OK");
    end else begin
      $display("[sound_voice_allocator_top] ERROR");
    end
    $finish;
  end

endmodule

// File: sound_voice_allocator_top.f
+incdir+hdl
hdl/sva_pkg.sv
hdl/sva_ifs.sv
hdl/sva_ram.sv
hdl/sva_ctrl.sv
hdl/sound_voice_allocator_top.sv
hdl/sva_checker.sv
tb/tb.sv
